[rtl/stlex_pkg.sv]
// Shared types and constants for the source text lexer.
// Token kind codes, named source bytes and the token record used by the
// core and the top level. No dependencies.
`default_nettype none

package stlex_pkg;

  localparam int KIND_W = 6;
  localparam int LINE_OUT_W = 16;
  localparam int COL_OUT_W = 9;
  localparam int LEN_OUT_W = 9;

  // Token kinds
  localparam logic [KIND_W-1:0] K_ENDLINE = 6'd0;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd1;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd2;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd3;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd4;
  localparam logic [KIND_W-1:0] K_LBRACK  = 6'd5;
  localparam logic [KIND_W-1:0] K_RBRACK  = 6'd6;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd7;
  localparam logic [KIND_W-1:0] K_INC     = 6'd8;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd9;
  localparam logic [KIND_W-1:0] K_RARROW  = 6'd10;
  localparam logic [KIND_W-1:0] K_DEC     = 6'd11;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd12;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd13;
  localparam logic [KIND_W-1:0] K_BSLASH  = 6'd14;
  localparam logic [KIND_W-1:0] K_PERCENT = 6'd15;
  localparam logic [KIND_W-1:0] K_AMP     = 6'd16;
  localparam logic [KIND_W-1:0] K_PIPE    = 6'd17;
  localparam logic [KIND_W-1:0] K_CARET   = 6'd18;
  localparam logic [KIND_W-1:0] K_TILDE   = 6'd19;
  localparam logic [KIND_W-1:0] K_BANG    = 6'd20;
  localparam logic [KIND_W-1:0] K_QMARK   = 6'd21;
  localparam logic [KIND_W-1:0] K_AT      = 6'd22;
  localparam logic [KIND_W-1:0] K_HASH    = 6'd23;
  localparam logic [KIND_W-1:0] K_LTHAN   = 6'd24;
  localparam logic [KIND_W-1:0] K_LARROW  = 6'd25;
  localparam logic [KIND_W-1:0] K_LTHANEQ = 6'd26;
  localparam logic [KIND_W-1:0] K_GTHAN   = 6'd27;
  localparam logic [KIND_W-1:0] K_GTHANEQ = 6'd28;
  localparam logic [KIND_W-1:0] K_EQUALS  = 6'd29;
  localparam logic [KIND_W-1:0] K_EQUIV   = 6'd30;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd31;
  localparam logic [KIND_W-1:0] K_COLON   = 6'd32;
  localparam logic [KIND_W-1:0] K_PERIOD  = 6'd33;
  localparam logic [KIND_W-1:0] K_STR     = 6'd34;
  localparam logic [KIND_W-1:0] K_INT     = 6'd35;
  localparam logic [KIND_W-1:0] K_FLOAT   = 6'd36;
  localparam logic [KIND_W-1:0] K_WORD    = 6'd37;
  localparam logic [KIND_W-1:0] K_NONE    = 6'd63;

  // Named source bytes
  localparam logic [7:0] CH_NL         = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_F          = 8'h66;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_SEMI       = 8'h3B;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [LINE_OUT_W-1:0] line;
    logic [COL_OUT_W-1:0]  column;
    logic [LEN_OUT_W-1:0]  length;
    logic                  unterm;
  } token_t;

  // Up to three tokens from one byte, in order; valid bits may have gaps
  typedef struct packed {
    logic [2:0]   valid;
    token_t [2:0] tok;
  } tok_set_t;

endpackage

`default_nettype wire

[rtl/stlex_core.sv]
// Lexer state and per-byte token logic: one byte in, up to three tokens out.
// Depends on stlex_pkg.
`default_nettype none

module stlex_core
  import stlex_pkg::*;
#(
  parameter int MAX_LINE   = 256,
  parameter int LINE_LIMIT = 65535
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_input,
  input  wire logic [7:0] comment_char,
  output tok_set_t        toks
);

  localparam int CW = $clog2(MAX_LINE + 2);
  localparam int LW = $clog2(LINE_LIMIT + 1);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_OP, MODE_STRING, MODE_COMMENT
  } mode_t;

  mode_t          mode, mode_next;
  logic [7:0]     held, held_next;
  logic [CW-1:0]  plen, plen_next;
  logic [CW-1:0]  psc, psc_next;
  logic [CW-1:0]  col, col_next;
  logic [LW-1:0]  line, line_next;
  logic           saw_dot, saw_dot_next;
  logic           ends_f, ends_f_next;
  logic           last_endl, last_endl_next;
  logic           any_sent, any_sent_next;

  logic           is_digit, is_alpha, is_ident, is_space, is_op, is_nl;
  logic [KIND_W-1:0] pk;
  logic           done, newline, split_end, line_end;
  mode_t          mode_a, mode_b;
  logic [CW-1:0]  len_a, len_b, psc_b, col1, end_col;
  logic [7:0]     held_b;
  logic           saw_a, saw_b, endf_a, endf_b;
  logic           v0, v1, v2;
  token_t         t0, t1, t2;

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "\\":    k = K_BSLASH;
      "%":     k = K_PERCENT;
      "&":     k = K_AMP;
      "|":     k = K_PIPE;
      "^":     k = K_CARET;
      "~":     k = K_TILDE;
      "!":     k = K_BANG;
      "?":     k = K_QMARK;
      "@":     k = K_AT;
      "#":     k = K_HASH;
      ",":     k = K_COMMA;
      ":":     k = K_COLON;
      CH_DOT:  k = K_PERIOD;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] a, input logic [7:0] s);
    logic [KIND_W-1:0] k;
    case (a)
      CH_PLUS:  k = (s == CH_PLUS) ? K_INC : K_PLUS;
      CH_MINUS: k = (s == CH_GT) ? K_RARROW : ((s == CH_MINUS) ? K_DEC : K_MINUS);
      CH_LT:    k = (s == CH_MINUS) ? K_LARROW : ((s == CH_EQ) ? K_LTHANEQ : K_LTHAN);
      CH_GT:    k = (s == CH_EQ) ? K_GTHANEQ : K_GTHAN;
      default:  k = (s == CH_EQ) ? K_EQUIV : K_EQUALS;
    endcase
    return k;
  endfunction

  function automatic token_t mk_tok(input logic [KIND_W-1:0] k, input logic [CW-1:0] c,
                                    input logic [CW-1:0] l, input logic u,
                                    input logic [LW-1:0] ln);
    token_t     t;
    logic [31:0] cx, lx, nx;
    cx = 32'(c);
    lx = 32'(l);
    nx = 32'(ln);
    t.kind   = k;
    t.line   = nx[LINE_OUT_W-1:0];
    t.column = cx[COL_OUT_W-1:0];
    t.length = lx[LEN_OUT_W-1:0];
    t.unterm = u;
    return t;
  endfunction

  function automatic token_t flush_tok(input mode_t m, input logic [CW-1:0] sc,
                                       input logic [CW-1:0] l, input logic [7:0] h,
                                       input logic dot, input logic f,
                                       input logic [LW-1:0] ln);
    token_t t;
    case (m)
      MODE_NUMBER: t = mk_tok((dot || f) ? K_FLOAT : K_INT, sc, l, 1'b0, ln);
      MODE_OP:     t = mk_tok(op_kind(h, 8'h00), sc, CW'(1), 1'b0, ln);
      MODE_STRING: t = mk_tok(K_STR, sc, l, 1'b1, ln);
      default:     t = mk_tok(K_WORD, sc, l, 1'b0, ln);
    endcase
    return t;
  endfunction

  function automatic logic has_pending(input mode_t m);
    return (m == MODE_WORD) || (m == MODE_NUMBER) || (m == MODE_OP) || (m == MODE_STRING);
  endfunction

  always_comb begin
    is_digit = (char_byte >= "0") && (char_byte <= "9");
    is_alpha = ((char_byte >= "A") && (char_byte <= "Z")) ||
               ((char_byte >= "a") && (char_byte <= "z"));
    is_ident = is_digit || is_alpha || (char_byte == CH_UNDERSCORE);
    is_space = (char_byte == CH_SPACE) || (char_byte == CH_TAB) || (char_byte == CH_CR);
    is_op    = (char_byte == CH_PLUS) || (char_byte == CH_MINUS) || (char_byte == CH_LT) ||
               (char_byte == CH_GT) || (char_byte == CH_EQ);
    is_nl    = (char_byte == CH_NL);
    pk       = punct_kind(char_byte);

    // Continue or close the token in progress
    mode_a = mode;
    len_a  = plen;
    saw_a  = saw_dot;
    endf_a = ends_f;
    done   = 1'b0;
    v0     = 1'b0;
    t0     = '0;
    unique case (mode)
      MODE_WORD: begin
        if (is_ident) begin
          len_a = plen + CW'(1);
          done  = 1'b1;
        end else begin
          v0     = 1'b1;
          t0     = flush_tok(mode, psc, plen, held, saw_dot, ends_f, line);
          mode_a = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit || char_byte == CH_DOT || char_byte == CH_F) begin
          len_a  = plen + CW'(1);
          saw_a  = saw_dot || (char_byte == CH_DOT);
          endf_a = (char_byte == CH_F);
          done   = 1'b1;
        end else begin
          v0     = 1'b1;
          t0     = flush_tok(mode, psc, plen, held, saw_dot, ends_f, line);
          mode_a = MODE_IDLE;
        end
      end
      MODE_OP: begin
        v0     = 1'b1;
        mode_a = MODE_IDLE;
        if (is_op) begin
          t0   = mk_tok(op_kind(held, char_byte), psc, CW'(2), 1'b0, line);
          done = 1'b1;
        end else begin
          t0 = flush_tok(mode, psc, plen, held, saw_dot, ends_f, line);
        end
      end
      MODE_STRING: begin
        if (char_byte == CH_QUOTE) begin
          len_a  = plen + CW'(1);
          v0     = 1'b1;
          t0     = mk_tok(K_STR, psc, plen + CW'(1), 1'b0, line);
          mode_a = MODE_IDLE;
          done   = 1'b1;
        end else if (!is_nl) begin
          len_a = plen + CW'(1);
          done  = 1'b1;
        end
      end
      MODE_COMMENT: begin
        done = !is_nl;
      end
      default: ;
    endcase

    // Start a new token or end the line
    newline = is_nl && !done;
    mode_b  = mode_a;
    psc_b   = psc;
    len_b   = len_a;
    held_b  = held;
    saw_b   = saw_a;
    endf_b  = endf_a;
    v1      = 1'b0;
    t1      = '0;
    if (!done) begin
      if (is_nl) begin
        // an open string is closed by the newline
        if (mode_a == MODE_STRING) begin
          v1 = 1'b1;
          t1 = mk_tok(K_STR, psc, len_a, 1'b1, line);
        end
        mode_b = MODE_IDLE;
      end else if (is_space) begin
        mode_b = mode_a;
      end else if (char_byte == comment_char) begin
        mode_b = MODE_COMMENT;
      end else if (char_byte == CH_QUOTE) begin
        mode_b = MODE_STRING;
        psc_b  = col;
        len_b  = CW'(1);
      end else if (is_op) begin
        mode_b = MODE_OP;
        psc_b  = col;
        len_b  = CW'(1);
        held_b = char_byte;
      end else if (pk != K_NONE) begin
        v1 = 1'b1;
        t1 = mk_tok(pk, col, CW'(1), 1'b0, line);
      end else if (is_digit) begin
        mode_b = MODE_NUMBER;
        psc_b  = col;
        len_b  = CW'(1);
        saw_b  = 1'b0;
        endf_b = 1'b0;
      end else if (is_ident) begin
        mode_b = MODE_WORD;
        psc_b  = col;
        len_b  = CW'(1);
      end else begin
        v1 = 1'b1;
        t1 = mk_tok(K_WORD, col, CW'(1), 1'b0, line);
      end
    end

    // End of input or line split: flush whatever is still open
    col1      = col + CW'(1);
    split_end = !newline && (end_of_input || (col1 > CW'(MAX_LINE)));
    if (split_end && !v1 && has_pending(mode_b)) begin
      v1 = 1'b1;
      t1 = flush_tok(mode_b, psc_b, len_b, held_b, saw_b, endf_b, line);
    end
    line_end = newline || split_end;
    end_col  = newline ? col : ((col1 > CW'(MAX_LINE)) ? CW'(MAX_LINE) : col1);

    // End of line: never first, never twice in a row
    v2 = line_end && (v0 || v1 || (any_sent && !last_endl));
    t2 = mk_tok(K_ENDLINE, end_col, '0, 1'b0, line);

    mode_next      = line_end ? MODE_IDLE : mode_b;
    held_next      = held_b;
    plen_next      = len_b;
    psc_next       = psc_b;
    saw_dot_next   = saw_b;
    ends_f_next    = endf_b;
    col_next       = line_end ? CW'(1) : col1;
    line_next      = (line_end && (line < LW'(LINE_LIMIT))) ? line + LW'(1) : line;
    any_sent_next  = any_sent || v0 || v1;
    last_endl_next = v2 ? 1'b1 : ((v0 || v1) ? 1'b0 : last_endl);

    toks.valid = {v2, v1, v0};
    toks.tok   = {t2, t1, t0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      held      <= '0;
      plen      <= '0;
      psc       <= CW'(1);
      col       <= CW'(1);
      line      <= LW'(1);
      saw_dot   <= 1'b0;
      ends_f    <= 1'b0;
      last_endl <= 1'b0;
      any_sent  <= 1'b0;
    end else if (fire) begin
      mode      <= mode_next;
      held      <= held_next;
      plen      <= plen_next;
      psc       <= psc_next;
      col       <= col_next;
      line      <= line_next;
      saw_dot   <= saw_dot_next;
      ends_f    <= ends_f_next;
      last_endl <= last_endl_next;
      any_sent  <= any_sent_next;
    end
  end

endmodule

`default_nettype wire

[rtl/source_text_lexer_unit.sv]
// Top level of the source text lexer: input register, lexer core and
// a four-entry output queue. Depends on stlex_pkg and stlex_core.
//
//   channel  direction  handshake                 payload
//   src      in         src_valid / src_ready     char_byte, end_of_input
//   tok      out        tok_valid / tok_ready     token_kind .. last_in_run
//   cfg      in         cfg_write_en              cfg_write_data (comment byte)
//
// One byte per cycle when not stalled; each byte passes the input register, then the queue.
// The queue takes a byte's tokens only while it holds at most one entry, so a
// byte giving two or three tokens stalls the input until the queue holds at most one.
// A stalled output keeps the queue from taking tokens and then holds src_ready low.
// Reset (rst, synchronous) empties the queue and restores the comment byte.
`default_nettype none

module source_text_lexer_unit
  import stlex_pkg::*;
#(
  parameter int MAX_LINE   = 256,
  parameter int LINE_LIMIT = 65535
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  src_valid,
  output logic                       src_ready,
  input  wire logic [7:0]            char_byte,
  input  wire logic                  end_of_input,
  input  wire logic                  cfg_write_en,
  input  wire logic [7:0]            cfg_write_data,
  output logic                       tok_valid,
  input  wire logic                  tok_ready,
  output logic [KIND_W-1:0]          token_kind,
  output logic [LINE_OUT_W-1:0]      line_number,
  output logic [COL_OUT_W-1:0]       start_column,
  output logic [LEN_OUT_W-1:0]       token_length,
  output logic                       unterminated,
  output logic                       last_in_run
);

  localparam int QDEPTH = 4;
  localparam int QIW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    token_t tok;
    logic   last;
  } qent_t;

  logic           in_valid_q;
  logic [7:0]     byte_q;
  logic           eoi_q;
  logic [7:0]     comment_char;
  logic           fire, pop;
  tok_set_t       toks;

  qent_t          q [QDEPTH];
  qent_t          q_next [QDEPTH];
  logic [QCW-1:0] qcnt, qcnt_next, base;
  logic [QIW-1:0] pos [3];
  logic [2:0]     is_last;

  stlex_core #(
    .MAX_LINE   (MAX_LINE),
    .LINE_LIMIT (LINE_LIMIT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .char_byte    (byte_q),
    .end_of_input (eoi_q),
    .comment_char (comment_char),
    .toks         (toks)
  );

  assign fire      = in_valid_q && (qcnt <= QCW'(1));
  assign src_ready = !in_valid_q || fire;
  assign tok_valid = (qcnt != '0);
  assign pop       = tok_valid && tok_ready;

  always_comb begin
    // pack the byte's tokens into consecutive queue slots
    pos[0]  = '0;
    pos[1]  = QIW'(toks.valid[0]);
    pos[2]  = QIW'(toks.valid[0]) + QIW'(toks.valid[1]);
    is_last = {toks.valid[2],
               toks.valid[1] && !toks.valid[2],
               toks.valid[0] && !toks.valid[1] && !toks.valid[2]};
    base    = qcnt - QCW'(pop);

    for (int j = 0; j < QDEPTH - 1; j++) begin
      q_next[j] = pop ? q[j + 1] : q[j];
    end
    q_next[QDEPTH-1] = q[QDEPTH-1];

    for (int i = 0; i < 3; i++) begin
      if (fire && toks.valid[i]) begin
        q_next[base[QIW-1:0] + pos[i]].tok  = toks.tok[i];
        q_next[base[QIW-1:0] + pos[i]].last = is_last[i];
      end
    end

    qcnt_next = base + (fire ? QCW'($countones(toks.valid)) : QCW'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q   <= 1'b0;
      qcnt         <= '0;
      comment_char <= CH_SEMI;
    end else begin
      if (src_ready) begin
        in_valid_q <= src_valid;
      end
      qcnt <= qcnt_next;
      if (cfg_write_en) begin
        comment_char <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      byte_q <= char_byte;
      eoi_q  <= end_of_input;
    end
    for (int j = 0; j < QDEPTH; j++) begin
      q[j] <= q_next[j];
    end
  end

  assign token_kind   = q[0].tok.kind;
  assign line_number  = q[0].tok.line;
  assign start_column = q[0].tok.column;
  assign token_length = q[0].tok.length;
  assign unterminated = q[0].tok.unterm;
  assign last_in_run  = q[0].last;

`ifndef SYNTHESIS
  a_qcnt_bound: assert property (@(posedge clk) disable iff (rst)
    qcnt <= QCW'(QDEPTH))
    else $error("output queue overfilled");

  a_unterm_string: assert property (@(posedge clk) disable iff (rst)
    tok_valid && unterminated |-> token_kind == K_STR)
    else $error("unterminated flag on a non-string item");

  a_endline_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && token_kind == K_ENDLINE |-> token_length == '0 && !unterminated)
    else $error("end of line item with length or flag");

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !fire |=> in_valid_q && $stable(byte_q) && $stable(eoi_q))
    else $error("waiting byte lost or changed");
`endif

endmodule

`default_nettype wire
